// ===== sv/ampq_pkg.sv =====
// ----------------------------------------------------------------------------
// ampq_pkg
// Shared types and codes for the array min-priority queue: operation kinds,
// result status codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ampq_pkg;

  localparam int ValueW = 32;
  localparam int OccW   = 4;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // Capture the incoming transaction.
    logic exec;      // Enqueue, reject, or start the minimum scan.
    logic scan;      // One comparator step of the minimum scan.
    logic shift;     // Remove the minimum and close the gap.
    logic load_out;  // Move the pending result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // Captured item is a dequeue on a non-empty queue.
    logic scan_done;  // Every occupied slot has been compared.
    logic out_free;   // The output register can take a new result.
  } sts_t;

endpackage

// ===== sv/array_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// array_min_priority_queue
// Bounded min-priority queue kept as an unsorted register array; enqueue
// appends at the tail, dequeue removes the oldest smallest signed value.
// ----------------------------------------------------------------------------
// Sequence: an enqueue or a rejected item goes through execute and then has
//   its result loaded into the output register; a dequeue on a non-empty
//   queue adds the scan, which compares one stored entry per cycle on a
//   single shared comparator, and the shift before the load.
// Throughput: one item at a time; the next item can be accepted once the
//   result is in the output register, even while that result is stalled.
// Reset: asynchronous, active low; clears the occupancy, the controller and
//   the output valid. Stored entries are not cleared.
module array_min_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic signed [ampq_pkg::ValueW-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [ampq_pkg::ValueW-1:0] min_value_o,
  output logic [ampq_pkg::OccW-1:0]          occupancy_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  ampq_pkg::cmd_t cmd;
  ampq_pkg::sts_t sts;

  ampq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ampq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .min_value_o (min_value_o),
    .occupancy_o (occupancy_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  // An accepted transaction blocks the input until its result is produced.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transaction was accepted");

  // A new result is loaded only when the output register has room.
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a stalled output");

  // Rejection status agrees with the reported flags.
  a_reject_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ampq_pkg::ST_FULL) |-> is_full_o)
    else $error("full rejection without full flag");

  a_empty_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ampq_pkg::ST_EMPTY) |-> is_empty_o)
    else $error("empty rejection without empty flag");

endmodule

// ===== sv/ampq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ampq_ctrl
// Sequencing state machine of the priority queue: captures one transaction,
// steps the datapath through execute and, for a dequeue on a non-empty
// queue, scan and shift, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ampq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ampq_pkg::sts_t sts_i,
  output ampq_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register has room.
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== sv/ampq_dp.sv =====
// ----------------------------------------------------------------------------
// ampq_dp
// Datapath of the priority queue: the entry register array, the occupancy
// counter, one shared signed comparator for the minimum scan, the parallel
// shift-down and the output register.
// ----------------------------------------------------------------------------
module ampq_dp #(
  parameter int DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ampq_pkg::cmd_t                    cmd_i,
  output ampq_pkg::sts_t                    sts_o,
  input  logic                              kind_i,
  input  logic signed [ampq_pkg::ValueW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [ampq_pkg::ValueW-1:0] min_value_o,
  output logic [ampq_pkg::OccW-1:0]         occupancy_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ampq_pkg::ValueW-1:0] entries_q [DEPTH];
  logic [CntW-1:0]                    count_q;
  logic                               kind_q;
  logic signed [ampq_pkg::ValueW-1:0] value_q;
  logic signed [ampq_pkg::ValueW-1:0] best_val_q;
  logic [IdxW-1:0]                    best_idx_q;
  logic [CntW-1:0]                    scan_idx_q;
  ampq_pkg::status_e                  res_status_q;

  logic                               out_valid_q;
  ampq_pkg::status_e                  out_status_q;
  logic signed [ampq_pkg::ValueW-1:0] out_min_q;
  logic [ampq_pkg::OccW-1:0]          out_occ_q;
  logic                               out_empty_q;
  logic                               out_full_q;

  logic                               is_full;
  logic                               is_empty;
  logic                               scan_done;
  logic signed [ampq_pkg::ValueW-1:0] scan_val;

  assign is_full   = (count_q == CntW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign scan_done = (scan_idx_q >= count_q);
  assign scan_val  = entries_q[scan_idx_q[IdxW-1:0]];

  assign sts_o.need_scan = (kind_q == ampq_pkg::KIND_DEQ) && !is_empty;
  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Captured transaction and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      best_idx_q <= '0;
      best_val_q <= entries_q[0];
      scan_idx_q <= CntW'(1);
      if (kind_q == ampq_pkg::KIND_ENQ) begin
        res_status_q <= is_full ? ampq_pkg::ST_FULL : ampq_pkg::ST_ENQ;
      end else begin
        res_status_q <= is_empty ? ampq_pkg::ST_EMPTY : ampq_pkg::ST_DEQ;
      end
    end
    if (cmd_i.scan && !scan_done) begin
      // Strict less-than keeps the oldest entry on ties.
      if (scan_val < best_val_q) begin
        best_val_q <= scan_val;
        best_idx_q <= scan_idx_q[IdxW-1:0];
      end
      scan_idx_q <= scan_idx_q + CntW'(1);
    end
  end

  // Entry array: tail write on enqueue, parallel shift-down on dequeue.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && kind_q == ampq_pkg::KIND_ENQ && !is_full) begin
      entries_q[count_q[IdxW-1:0]] <= value_q;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IdxW'(i) >= best_idx_q && CntW'(i + 1) < count_q) begin
          entries_q[i] <= entries_q[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec && kind_q == ampq_pkg::KIND_ENQ && !is_full) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.shift) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_min_q    <= (res_status_q == ampq_pkg::ST_DEQ) ? best_val_q : '0;
      out_occ_q    <= ampq_pkg::OccW'(count_q);
      out_empty_q  <= is_empty;
      out_full_q   <= is_full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign min_value_o = out_min_q;
  assign occupancy_o = out_occ_q;
  assign is_empty_o  = out_empty_q;
  assign is_full_o   = out_full_q;

endmodule
